/* hw/rtl/bbe_pkg.sv */
// Shared types, register indexes and the reciprocal table of the 3x3 box blur.
// Used by the front, back and top-level modules; depends on nothing else.
package bbe_pkg;

  localparam int unsigned PIX_W = 24;
  localparam int unsigned SUM_W = 12;
  localparam int unsigned CNT_W = 4;
  localparam int unsigned RCP_W = 17;
  localparam int unsigned OUT_ROW_W = 12;
  localparam int unsigned OUT_COL_W = 10;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 13;
  localparam int unsigned CFG_WIDTH_W = 11;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

  typedef logic [PIX_W-1:0] pix_t;

  typedef struct packed {
    logic [8:0][PIX_W-1:0]  win;
    logic [OUT_ROW_W-1:0]   row;
    logic [OUT_COL_W-1:0]   col;
    logic                   ige1;
    logic                   ige2;
    logic                   jge1;
    logic                   jge2;
    logic                   row_end;
    logic                   last_row;
  } job_t;

  function automatic logic [RCP_W-1:0] recip(input logic [CNT_W-1:0] n);
    logic [RCP_W-1:0] r;
    case (n)
      4'd2:    r = 17'd32768;
      4'd3:    r = 17'd21846;
      4'd4:    r = 17'd16384;
      4'd5:    r = 17'd13108;
      4'd6:    r = 17'd10923;
      4'd7:    r = 17'd9363;
      4'd8:    r = 17'd8192;
      4'd9:    r = 17'd7282;
      default: r = 17'd65536;
    endcase
    return r;
  endfunction

endpackage

/* hw/rtl/bbe_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// Used for the line stores; no dependencies.
module bbe_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                                        clk_i,
  input  logic                                        we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0]  waddr_i,
  input  logic [WIDTH-1:0]                            wdata_i,
  input  logic                                        re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0]  raddr_i,
  output logic [WIDTH-1:0]                            rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

/* hw/rtl/bbe_fifo.sv */
// Small job queue between the front and back parts of the blur.
// Generic in width and depth; no dependencies.
module bbe_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] data_o
);

  localparam int unsigned PW = DEPTH > 1 ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wptr_q, rptr_q;
  logic [PW:0]      cnt_q;

  assign full_o  = (cnt_q == (PW+1)'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= (wptr_q == PW'(DEPTH-1)) ? '0 : wptr_q + 1'b1;
      end
      if (pop_i) begin
        rptr_q <= (rptr_q == PW'(DEPTH-1)) ? '0 : rptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= data_i;
    end
  end

endmodule

/* hw/rtl/bbe_front.sv */
// Front part of the blur: takes pixels, keeps counters, line stores and window.
// Depends on bbe_pkg and bbe_ram; emits one job per pixel into the queue.
module bbe_front #(
  parameter int unsigned MAX_WIDTH = 1024,
  parameter int unsigned MAX_HEIGHT = 4096
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [(MAX_WIDTH > 1 ? $clog2(MAX_WIDTH) : 1)-1:0]   wm1_i,
  input  logic [(MAX_HEIGHT > 1 ? $clog2(MAX_HEIGHT) : 1)-1:0] hm1_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  bbe_pkg::pix_t         pix_i,
  input  logic                  job_full_i,
  output logic                  job_valid_o,
  output bbe_pkg::job_t         job_o
);

  localparam int unsigned CW = MAX_WIDTH > 1 ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned RW = MAX_HEIGHT > 1 ? $clog2(MAX_HEIGHT) : 1;

  typedef enum logic {
    ST_IDLE,
    ST_WRITE
  } state_e;

  state_e                      state_q;
  logic [CW-1:0]               col_q, ju, ju_q;
  logic [RW-1:0]               row_q, iu, iu_q;
  logic                        row_end, last_row, row_end_q, last_row_q;
  logic                        accept;
  bbe_pkg::pix_t               px_q;
  logic [8:0][bbe_pkg::PIX_W-1:0] win_q, win_d;
  bbe_pkg::pix_t               prev_rd, older_rd;

  assign ju       = (col_q >= wm1_i) ? wm1_i : col_q;
  assign iu       = (row_q >= hm1_i) ? hm1_i : row_q;
  assign row_end  = (ju == wm1_i);
  assign last_row = (iu == hm1_i);

  assign in_ready_o  = (state_q == ST_IDLE) && !job_full_i;
  assign accept      = in_valid_i && in_ready_o;
  assign job_valid_o = (state_q == ST_WRITE);

  bbe_ram #(.WIDTH(bbe_pkg::PIX_W), .DEPTH(MAX_WIDTH)) u_prev (
    .clk_i   (clk_i),
    .we_i    (job_valid_o),
    .waddr_i (ju_q),
    .wdata_i (px_q),
    .re_i    (accept),
    .raddr_i (ju),
    .rdata_o (prev_rd)
  );

  bbe_ram #(.WIDTH(bbe_pkg::PIX_W), .DEPTH(MAX_WIDTH)) u_older (
    .clk_i   (clk_i),
    .we_i    (job_valid_o),
    .waddr_i (ju_q),
    .wdata_i (prev_rd),
    .re_i    (accept),
    .raddr_i (ju),
    .rdata_o (older_rd)
  );

  always_comb begin
    for (int t = 0; t < 3; t++) begin
      win_d[t*3+0] = win_q[t*3+1];
      win_d[t*3+1] = win_q[t*3+2];
    end
    win_d[2] = older_rd;
    win_d[5] = prev_rd;
    win_d[8] = px_q;
  end

  always_comb begin
    job_o.win      = win_d;
    job_o.row      = bbe_pkg::OUT_ROW_W'(iu_q);
    job_o.col      = bbe_pkg::OUT_COL_W'(ju_q);
    job_o.ige1     = (iu_q != '0);
    job_o.ige2     = ((iu_q >> 1) != '0);
    job_o.jge1     = (ju_q != '0);
    job_o.jge2     = ((ju_q >> 1) != '0);
    job_o.row_end  = row_end_q;
    job_o.last_row = last_row_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      col_q   <= '0;
      row_q   <= '0;
      win_q   <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            state_q <= ST_WRITE;
            if (row_end) begin
              col_q <= '0;
              row_q <= last_row ? '0 : iu + 1'b1;
            end else begin
              col_q <= ju + 1'b1;
              row_q <= iu;
            end
          end
        end
        ST_WRITE: begin
          win_q   <= win_d;
          state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ju_q       <= ju;
      iu_q       <= iu;
      row_end_q  <= row_end;
      last_row_q <= last_row;
      px_q       <= pix_i;
    end
  end

endmodule

/* hw/rtl/bbe_back.sv */
// Back part of the blur: turns each job into up to four averaged results.
// Depends on bbe_pkg; a sum stage and a reciprocal-multiply output stage.
module bbe_back (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              job_valid_i,
  input  bbe_pkg::job_t                     job_i,
  output logic                              job_pop_o,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [7:0]                        blue_out_o,
  output logic [7:0]                        green_out_o,
  output logic [7:0]                        red_out_o,
  output logic [bbe_pkg::OUT_ROW_W-1:0]     out_row_o,
  output logic [bbe_pkg::OUT_COL_W-1:0]     out_col_o,
  output logic                              last_of_run_o
);

  localparam int unsigned PW = bbe_pkg::SUM_W + bbe_pkg::RCP_W;

  bbe_pkg::job_t                  job_q;
  logic [3:0]                     mask_q, mask_d, sel, rem, new_mask;
  logic                           out_adv, s1_adv, issue, load;
  logic                           roff, coff;
  logic [2:0]                     rin, cin;
  logic [2:0][bbe_pkg::SUM_W-1:0] sum_d, sum_q;
  logic [bbe_pkg::CNT_W-1:0]      n_d, n_q;
  logic [bbe_pkg::OUT_ROW_W-1:0]  r_d, r_q;
  logic [bbe_pkg::OUT_COL_W-1:0]  c_d, c_q;
  logic                           last_d, last_q, s1_v_q;
  logic [bbe_pkg::RCP_W-1:0]      rcp;
  logic [2:0][PW-1:0]             prod;

  assign out_adv = !out_valid_o || out_ready_i;
  assign s1_adv  = !s1_v_q || out_adv;
  assign sel     = mask_q & (~mask_q + 4'd1);
  assign issue   = s1_adv && (mask_q != '0);
  assign rem     = issue ? (mask_q & ~sel) : mask_q;
  assign load    = job_valid_i && (rem == '0);
  assign job_pop_o = load;

  assign new_mask = {job_i.last_row && job_i.row_end,
                     job_i.last_row && job_i.jge1,
                     job_i.ige1 && job_i.row_end,
                     job_i.ige1 && job_i.jge1};
  assign mask_d = load ? new_mask : rem;

  always_comb begin
    roff   = sel[2] | sel[3];
    coff   = sel[1] | sel[3];
    rin[0] = !roff && job_q.ige2;
    rin[1] = job_q.ige1;
    rin[2] = 1'b1;
    cin[0] = !coff && job_q.jge2;
    cin[1] = job_q.jge1;
    cin[2] = 1'b1;
    sum_d  = '0;
    n_d    = '0;
    for (int t = 0; t < 3; t++) begin
      for (int s = 0; s < 3; s++) begin
        if (rin[t] && cin[s]) begin
          for (int ch = 0; ch < 3; ch++) begin
            sum_d[ch] = sum_d[ch] + bbe_pkg::SUM_W'(job_q.win[t*3+s][ch*8 +: 8]);
          end
          n_d = n_d + 1'b1;
        end
      end
    end
    r_d    = roff ? job_q.row : job_q.row - 1'b1;
    c_d    = coff ? job_q.col : job_q.col - 1'b1;
    last_d = ((mask_q & ~sel) == '0);
  end

  assign rcp = bbe_pkg::recip(n_q);

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      prod[ch] = PW'(sum_q[ch]) * PW'(rcp);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q      <= '0;
      s1_v_q      <= 1'b0;
      out_valid_o <= 1'b0;
    end else begin
      mask_q <= mask_d;
      if (s1_adv) begin
        s1_v_q <= issue;
      end
      if (out_adv) begin
        out_valid_o <= s1_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      job_q <= job_i;
    end
    if (issue) begin
      sum_q  <= sum_d;
      n_q    <= n_d;
      r_q    <= r_d;
      c_q    <= c_d;
      last_q <= last_d;
    end
    if (out_adv && s1_v_q) begin
      blue_out_o    <= prod[0][16 +: 8];
      green_out_o   <= prod[1][16 +: 8];
      red_out_o     <= prod[2][16 +: 8];
      out_row_o     <= r_q;
      out_col_o     <= c_q;
      last_of_run_o <= last_q;
    end
  end

endmodule

/* hw/rtl/box_blur_3x3_edge_aware.sv */
// Streaming 3x3 box blur of RGB pixels in raster order; each result is the truncated
// per-channel mean over the in-image neighbours, tagged with its row and column. The
// front part takes no new pixel while it writes the last one back to the line stores;
// the back part delivers one result per cycle while the output is ready, and a pixel
// releases 0 to 4 results, with a two-entry queue between them. The configuration
// registers are held here; the user must write them only while idle (left unchecked).
module box_blur_3x3_edge_aware #(
  parameter int unsigned MAX_WIDTH = 1024,
  parameter int unsigned MAX_HEIGHT = 4096
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [bbe_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [bbe_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [7:0]                         blue_in_i,
  input  logic [7:0]                         green_in_i,
  input  logic [7:0]                         red_in_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [7:0]                         blue_out_o,
  output logic [7:0]                         green_out_o,
  output logic [7:0]                         red_out_o,
  output logic [bbe_pkg::OUT_ROW_W-1:0]      out_row_o,
  output logic [bbe_pkg::OUT_COL_W-1:0]      out_col_o,
  output logic                               last_of_run_o
);

  localparam int unsigned CW = MAX_WIDTH > 1 ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned RW = MAX_HEIGHT > 1 ? $clog2(MAX_HEIGHT) : 1;

  logic [bbe_pkg::CFG_WIDTH_W-1:0] w_cfg_q;
  logic [bbe_pkg::CFG_DATA_W-1:0]  h_cfg_q;
  logic [CW-1:0]                   wm1;
  logic [RW-1:0]                   hm1;
  logic                            job_full, fr_valid, q_valid, q_pop;
  bbe_pkg::job_t                   fr_job, q_job;
  bbe_pkg::pix_t                   pix;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_cfg_q <= 11'd640;
      h_cfg_q <= 13'd480;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        bbe_pkg::REG_IMAGE_WIDTH:  w_cfg_q <= cfg_data_i[bbe_pkg::CFG_WIDTH_W-1:0];
        bbe_pkg::REG_IMAGE_HEIGHT: h_cfg_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (w_cfg_q == '0) begin
      wm1 = '0;
    end else if (32'(w_cfg_q) > 32'(MAX_WIDTH)) begin
      wm1 = CW'(MAX_WIDTH - 1);
    end else begin
      wm1 = CW'(w_cfg_q - 1'b1);
    end
    if (h_cfg_q == '0) begin
      hm1 = '0;
    end else if (32'(h_cfg_q) > 32'(MAX_HEIGHT)) begin
      hm1 = RW'(MAX_HEIGHT - 1);
    end else begin
      hm1 = RW'(h_cfg_q - 1'b1);
    end
  end

  assign pix = {red_in_i, green_in_i, blue_in_i};

  bbe_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wm1_i       (wm1),
    .hm1_i       (hm1),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .pix_i       (pix),
    .job_full_i  (job_full),
    .job_valid_o (fr_valid),
    .job_o       (fr_job)
  );

  bbe_fifo #(.WIDTH($bits(bbe_pkg::job_t)), .DEPTH(2)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fr_valid),
    .data_i  (fr_job),
    .full_o  (job_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (q_job)
  );

  bbe_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .job_valid_i   (q_valid),
    .job_i         (q_job),
    .job_pop_o     (q_pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .blue_out_o    (blue_out_o),
    .green_out_o   (green_out_o),
    .red_out_o     (red_out_o),
    .out_row_o     (out_row_o),
    .out_col_o     (out_col_o),
    .last_of_run_o (last_of_run_o)
  );

endmodule

/* hw/rtl/bbe_checker.sv */
// Port-level checks for the box blur, bound to its top level.
// Depends on bbe_pkg for port widths.
module bbe_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               cfg_valid_i,
  input logic                               cfg_ready_o,
  input logic [bbe_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input logic [bbe_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input logic                               in_valid_i,
  input logic                               in_ready_o,
  input logic [7:0]                         blue_in_i,
  input logic [7:0]                         green_in_i,
  input logic [7:0]                         red_in_i,
  input logic                               out_valid_o,
  input logic                               out_ready_i,
  input logic [7:0]                         blue_out_o,
  input logic [7:0]                         green_out_o,
  input logic [7:0]                         red_out_o,
  input logic [bbe_pkg::OUT_ROW_W-1:0]      out_row_o,
  input logic [bbe_pkg::OUT_COL_W-1:0]      out_col_o,
  input logic                               last_of_run_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("Result beat dropped before it was taken.");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_row_o) && $stable(out_col_o)
      && $stable(blue_out_o) && $stable(last_of_run_o))
    else $error("Stalled result beat changed.");

  a_in_pace: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("Pixel taken in back-to-back cycles.");

  a_no_early_out: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("Result beat shown right after reset.");

endmodule

bind box_blur_3x3_edge_aware bbe_checker u_bbe_checker (.*);

/* test/box_blur_3x3_edge_aware_tb.sv */
// Self-checking testbench for the streaming 3x3 box blur, box_blur_3x3_edge_aware.
// A pixel driver and a result monitor run on the clock, and a built-in blur predictor
// supplies expected results. Depends on bbe_pkg and the RTL only.
module box_blur_3x3_edge_aware_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LINE_DEPTH = 1024;
  localparam int unsigned ROW_LIMIT = 4096;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned SETTLE_CYCLES = 20;

  typedef struct packed {
    logic [7:0]                    blue;
    logic [7:0]                    green;
    logic [7:0]                    red;
    logic [bbe_pkg::OUT_ROW_W-1:0] row;
    logic [bbe_pkg::OUT_COL_W-1:0] col;
    logic                          last;
  } blur_pix_t;

  typedef enum int {PIX_RANDOM, PIX_BLACK, PIX_WHITE, PIX_STRIPES} pix_mode_e;

  logic clk_i;
  logic rst_ni;
  logic cfg_valid_i;
  logic cfg_ready_o;
  logic [bbe_pkg::CFG_IDX_W-1:0] cfg_index_i;
  logic [bbe_pkg::CFG_DATA_W-1:0] cfg_data_i;
  logic in_valid_i;
  logic in_ready_o;
  logic [7:0] blue_in_i;
  logic [7:0] green_in_i;
  logic [7:0] red_in_i;
  logic out_valid_o;
  logic out_ready_i;
  logic [7:0] blue_out_o;
  logic [7:0] green_out_o;
  logic [7:0] red_out_o;
  logic [bbe_pkg::OUT_ROW_W-1:0] out_row_o;
  logic [bbe_pkg::OUT_COL_W-1:0] out_col_o;
  logic last_of_run_o;

  box_blur_3x3_edge_aware i_dut (.*);

  bbe_pkg::pix_t pixel_fifo[$];
  blur_pix_t     blur_fifo[$];
  bbe_pkg::pix_t prev_line[LINE_DEPTH];
  bbe_pkg::pix_t older_line[LINE_DEPTH];
  bbe_pkg::pix_t win[3][3];
  int unsigned row_cnt;
  int unsigned col_cnt;
  int unsigned width_reg;
  int unsigned height_reg;
  int unsigned cycles;
  int unsigned pixels_sent;
  int unsigned results_seen;
  int unsigned errors;
  bit          pixel_taken;
  bit          no_gaps;
  bit          hold_request;
  bit          hold_done;
  int unsigned hold_left;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int unsigned clamp_size(int unsigned v, int unsigned maxv);
    if (v == 0) return 1;
    return (v > maxv) ? maxv : v;
  endfunction

  function automatic blur_pix_t blur_at(int i, int j, int r, int c);
    blur_pix_t res;
    int unsigned sb, sg, sr, n;
    int prow, pcol;
    sb = 0; sg = 0; sr = 0; n = 0;
    for (int t = 0; t < 3; t++) begin
      prow = i - 2 + t;
      if (prow < 0 || prow < r - 1 || prow > r + 1) continue;
      for (int s = 0; s < 3; s++) begin
        pcol = j - 2 + s;
        if (pcol < 0 || pcol < c - 1 || pcol > c + 1) continue;
        sb += win[t][s][7:0];
        sg += win[t][s][15:8];
        sr += win[t][s][23:16];
        n++;
      end
    end
    if (n == 0) n = 1;
    res.blue = 8'(sb / n);
    res.green = 8'(sg / n);
    res.red = 8'(sr / n);
    res.row = bbe_pkg::OUT_ROW_W'(r);
    res.col = bbe_pkg::OUT_COL_W'(c);
    res.last = 1'b0;
    return res;
  endfunction

  task automatic predict_pixel(input bbe_pkg::pix_t px);
    blur_pix_t outs[4];
    int unsigned w, h, ju, iu;
    int k;
    bit row_end, last_row;
    w = clamp_size(width_reg, LINE_DEPTH);
    h = clamp_size(height_reg, ROW_LIMIT);
    ju = (col_cnt >= w - 1) ? w - 1 : col_cnt;
    iu = (row_cnt >= h - 1) ? h - 1 : row_cnt;
    row_end = (ju == w - 1);
    last_row = (iu == h - 1);
    k = 0;
    for (int t = 0; t < 3; t++) begin
      win[t][0] = win[t][1];
      win[t][1] = win[t][2];
    end
    win[0][2] = older_line[ju];
    win[1][2] = prev_line[ju];
    win[2][2] = px;
    older_line[ju] = prev_line[ju];
    prev_line[ju] = px;
    if (iu >= 1) begin
      if (ju >= 1) outs[k++] = blur_at(iu, ju, iu - 1, ju - 1);
      if (row_end) outs[k++] = blur_at(iu, ju, iu - 1, ju);
    end
    if (last_row) begin
      if (ju >= 1) outs[k++] = blur_at(iu, ju, iu, ju - 1);
      if (row_end) outs[k++] = blur_at(iu, ju, iu, ju);
    end
    if (k > 0) outs[k-1].last = 1'b1;
    for (int q = 0; q < k; q++) blur_fifo.push_back(outs[q]);
    if (row_end) begin
      col_cnt = 0;
      row_cnt = last_row ? 0 : iu + 1;
    end else begin
      col_cnt = ju + 1;
      row_cnt = iu;
    end
  endtask

  task automatic check_field(input string name, input int unsigned exp_v,
                             input int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
      errors++;
    end
  endtask

  // Results are checked before the accepted pixel is predicted in the same edge.
  always @(posedge clk_i) begin
    blur_pix_t exp_pix;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (blur_fifo.size() == 0) begin
        $error("Unexpected result beat at row %0d col %0d", out_row_o, out_col_o);
        errors++;
      end else begin
        exp_pix = blur_fifo.pop_front();
        check_field("blue_out", exp_pix.blue, blue_out_o);
        check_field("green_out", exp_pix.green, green_out_o);
        check_field("red_out", exp_pix.red, red_out_o);
        check_field("out_row", exp_pix.row, out_row_o);
        check_field("out_col", exp_pix.col, out_col_o);
        check_field("last_of_run", exp_pix.last, last_of_run_o);
      end
    end
    if (rst_ni && in_valid_i && in_ready_o) begin
      predict_pixel({red_in_i, green_in_i, blue_in_i});
      pixel_taken = 1'b1;
      pixels_sent++;
    end
  end

  always @(negedge clk_i) begin
    bbe_pkg::pix_t px;
    logic next_valid;
    next_valid = in_valid_i;
    if (!in_valid_i || pixel_taken) begin
      pixel_taken = 1'b0;
      next_valid = 1'b0;
      if (pixel_fifo.size() > 0 && (no_gaps || $urandom_range(99) >= 13)) begin
        px = pixel_fifo.pop_front();
        {red_in_i, green_in_i, blue_in_i} <= px;
        next_valid = 1'b1;
      end
    end
    in_valid_i <= next_valid;
  end

  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else if (hold_request && !hold_done) begin
      hold_done = 1'b1;
      hold_left = 300;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= no_gaps || ($urandom_range(99) >= 13);
    end
  end

  function automatic bbe_pkg::pix_t make_pixel(pix_mode_e mode, int unsigned n);
    case (mode)
      PIX_BLACK:   return '0;
      PIX_WHITE:   return '1;
      PIX_STRIPES: return n[0] ? 24'hFF00FF : 24'h00FF00;
      default:     return bbe_pkg::pix_t'($urandom);
    endcase
  endfunction

  task automatic wait_idle();
    while (pixel_fifo.size() > 0 || in_valid_i || blur_fifo.size() > 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [bbe_pkg::CFG_IDX_W-1:0] idx,
                           input int unsigned value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= bbe_pkg::CFG_DATA_W'(value);
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (idx == bbe_pkg::REG_IMAGE_WIDTH) width_reg = value & 32'h7FF;
    else height_reg = value & 32'h1FFF;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic int unsigned pixels_to_frame_end();
    int unsigned w, h, ju, iu;
    w = clamp_size(width_reg, LINE_DEPTH);
    h = clamp_size(height_reg, ROW_LIMIT);
    ju = (col_cnt >= w - 1) ? w - 1 : col_cnt;
    iu = (row_cnt >= h - 1) ? h - 1 : row_cnt;
    return (w - ju) + (h - 1 - iu) * w;
  endfunction

  // Pushes n pixels, or the rest of the frame when n is zero, then waits for idle.
  task automatic feed(input int unsigned n, input pix_mode_e mode);
    int unsigned cnt;
    cnt = (n == 0) ? pixels_to_frame_end() : n;
    for (int unsigned q = 0; q < cnt; q++) pixel_fifo.push_back(make_pixel(mode, q));
    wait_idle();
  endtask

  task automatic frame(input int unsigned w, input int unsigned h, input pix_mode_e mode);
    write_reg(bbe_pkg::REG_IMAGE_WIDTH, w);
    write_reg(bbe_pkg::REG_IMAGE_HEIGHT, h);
    feed(0, mode);
  endtask

  initial begin
    int unsigned rand_start;
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = bbe_pkg::REG_IMAGE_WIDTH;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    blue_in_i = '0;
    green_in_i = '0;
    red_in_i = '0;
    out_ready_i = 1'b0;
    width_reg = 640;
    height_reg = 480;
    for (int q = 0; q < LINE_DEPTH; q++) begin
      prev_line[q] = '0;
      older_line[q] = '0;
    end
    for (int t = 0; t < 3; t++) for (int s = 0; s < 3; s++) win[t][s] = '0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    feed(3, PIX_RANDOM);
    write_reg(bbe_pkg::REG_IMAGE_WIDTH, 2);
    write_reg(bbe_pkg::REG_IMAGE_HEIGHT, 3);
    feed(0, PIX_WHITE);
    frame(1, 1, PIX_WHITE);
    frame(0, 0, PIX_BLACK);
    frame(3, 3, PIX_WHITE);
    frame(3, 3, PIX_STRIPES);
    frame(1, 4, PIX_RANDOM);
    frame(4, 1, PIX_RANDOM);
    write_reg(bbe_pkg::REG_IMAGE_WIDTH, 2047);
    write_reg(bbe_pkg::REG_IMAGE_HEIGHT, 8191);
    feed(12, PIX_RANDOM);
    write_reg(bbe_pkg::REG_IMAGE_HEIGHT, 1);
    feed(4, PIX_RANDOM);
    write_reg(bbe_pkg::REG_IMAGE_WIDTH, 4);
    feed(0, PIX_RANDOM);

    rand_start = pixels_sent;
    hold_request = 1'b1;
    frame(6, 5, PIX_RANDOM);
    no_gaps = 1'b1;
    frame(7, 4, PIX_RANDOM);
    no_gaps = 1'b0;
    while (pixels_sent - rand_start < 110) begin
      frame(($urandom_range(9) == 0) ? 0 : $urandom_range(1, 8),
            ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 6), PIX_RANDOM);
    end
    write_reg(bbe_pkg::REG_IMAGE_WIDTH, 5);
    write_reg(bbe_pkg::REG_IMAGE_HEIGHT, 4);
    feed(7, PIX_RANDOM);
    write_reg(bbe_pkg::REG_IMAGE_HEIGHT, 2);
    feed(0, PIX_RANDOM);

    $display("Blur run: %0d pixels sent, %0d result beats checked across small, degenerate",
             pixels_sent, results_seen);
    $display("and saturated frame sizes, mid-frame shrinks and a long output hold-off.");
    if (errors == 0 && blur_fifo.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/bbe_pkg.sv
hw/rtl/bbe_ram.sv
hw/rtl/bbe_fifo.sv
hw/rtl/bbe_front.sv
hw/rtl/bbe_back.sv
hw/rtl/box_blur_3x3_edge_aware.sv
hw/rtl/bbe_checker.sv
test/box_blur_3x3_edge_aware_tb.sv
